FILE: hdl/jukes_cantor_pair_distance_core_macros.svh
// Assertion macros for the Jukes-Cantor pair distance core.
`ifndef JUKES_CANTOR_PAIR_DISTANCE_CORE_MACROS_SVH
`define JUKES_CANTOR_PAIR_DISTANCE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define JCPD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jcpd assertion failed");
`define JCPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jcpd assertion failed");
`else
`define JCPD_ASSERT_IMPL(label, ante, cons)
`define JCPD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/jcpd_pkg.sv
// Shared types and constants of the Jukes-Cantor pair distance core.
package jcpd_pkg;
  localparam int SUM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int BASE_W        = 8;
  localparam int WEIGHT_W      = 16;
  localparam int DIST_W        = 24;
  localparam int OSUM_W        = 32;
  localparam int STATUS_W      = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = '1;
  // round(0.75*ln2*2^28)
  localparam logic [27:0] LN2_075_Q28 = 28'd139548960;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SITES = 2'd1;
  localparam logic [STATUS_W-1:0] ST_INFINITE = 2'd2;

  localparam logic [BASE_W-1:0] CH_A = 8'h61;
  localparam logic [BASE_W-1:0] CH_C = 8'h63;
  localparam logic [BASE_W-1:0] CH_G = 8'h67;
  localparam logic [BASE_W-1:0] CH_T = 8'h74;
  localparam logic [BASE_W-1:0] CH_UP_A = 8'h41;
  localparam logic [BASE_W-1:0] CH_UP_Z = 8'h5A;
  localparam logic [BASE_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_NORM, S_LOG, S_MUL_LO, S_MUL_HI, S_DONE
  } state_t;
endpackage

FILE: hdl/jcpd_site_if.sv
// Site request channel of the Jukes-Cantor pair distance core.
interface jcpd_site_if;
  logic                            valid;
  logic                            ready;
  logic [jcpd_pkg::BASE_W-1:0]     base_first;
  logic [jcpd_pkg::BASE_W-1:0]     base_second;
  logic [jcpd_pkg::WEIGHT_W-1:0]   site_weight;
  logic                            last_site;
  modport source (output valid, base_first, base_second, site_weight, last_site,
                  input ready);
  modport sink (input valid, base_first, base_second, site_weight, last_site,
                output ready);
endinterface

FILE: hdl/jcpd_result_if.sv
// Result request channel of the Jukes-Cantor pair distance core.
interface jcpd_result_if;
  logic                            valid;
  logic                            ready;
  logic [jcpd_pkg::DIST_W-1:0]     distance;
  logic [jcpd_pkg::OSUM_W-1:0]     differing_weight;
  logic [jcpd_pkg::OSUM_W-1:0]     compared_weight;
  logic [jcpd_pkg::STATUS_W-1:0]   status;
  modport source (output valid, distance, differing_weight, compared_weight, status,
                  input ready);
  modport sink (input valid, distance, differing_weight, compared_weight, status,
                output ready);
endinterface

FILE: hdl/jukes_cantor_pair_distance_core.sv
// Jukes-Cantor pair distance core: site accumulation and bit-serial log2 distance.
//
//  channel | dir | request carries
//  sites   | in  | base_first, base_second, site_weight, last_site
//  result  | out | distance, differing_weight, compared_weight, status
//
// A site that is not the last is taken in S_IDLE; sites stream back to back.
// A last site starts the distance pass: a check state, then for each of the
// two logs the normalize state (one-bit shifts, then a load) and 30 squaring
// steps (one log2 bit each) on the shared 31x31 multiplier, then the low and
// high partial-product states and the output load state.
// sites.ready is low until the result is loaded; a stalled result holds it low.
// Reset is synchronous and clears both sums and the output valid.
`include "jukes_cantor_pair_distance_core_macros.svh"
module jukes_cantor_pair_distance_core #(
  parameter int SUM_WIDTH = jcpd_pkg::SUM_WIDTH_DEF,
  parameter int FRAC_BITS = jcpd_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  jcpd_site_if.sink     sites,
  jcpd_result_if.source result
);
  localparam int NW   = SUM_WIDTH + 2;
  localparam int NWX  = (NW > 31) ? NW : 31;
  localparam int EW   = $clog2(NWX);
  localparam int LW   = EW + 30;
  localparam int LO_W = 18;
  localparam int HI_W = LW - LO_W;
  localparam int PW   = LW + 28;
  localparam int SH   = 58 - FRAC_BITS;
  localparam int XW   = (SUM_WIDTH > 32) ? SUM_WIDTH : 32;

  function automatic logic [jcpd_pkg::BASE_W-1:0] lower(
    input logic [jcpd_pkg::BASE_W-1:0] c);
    return (c >= jcpd_pkg::CH_UP_A && c <= jcpd_pkg::CH_UP_Z) ?
           c + jcpd_pkg::CASE_OFS : c;
  endfunction

  function automatic logic is_certain(input logic [jcpd_pkg::BASE_W-1:0] c);
    return c == jcpd_pkg::CH_A || c == jcpd_pkg::CH_C ||
           c == jcpd_pkg::CH_G || c == jcpd_pkg::CH_T;
  endfunction

  jcpd_pkg::state_t state, state_next;

  logic [SUM_WIDTH-1:0] differ_sum, total_sum;
  logic [NW-1:0]        m_val;
  logic [NWX-1:0]       x;
  logic [EW-1:0]        e;
  logic [30:0]          m;
  logic [29:0]          frac;
  logic [4:0]           cnt;
  logic                 sel;
  logic [LW-1:0]        ln_n, diff;
  logic [PW-1:0]        prod;
  logic [jcpd_pkg::STATUS_W-1:0] status_r;

  logic accept, last_step, load_out, in_ready;
  logic a_cert, b_cert, use_site, differ;
  logic [jcpd_pkg::BASE_W-1:0] la, lb;
  logic [SUM_WIDTH:0] tot_add, dif_add;
  logic [NW-1:0] n_c, d4_c;
  logic [61:0] sq;
  logic [LW-1:0] ln_cur;
  logic [LO_W+27:0] p_lo;
  logic [HI_W+27:0] p_hi;
  logic [PW-1:0] shv;
  logic [jcpd_pkg::DIST_W-1:0] dist_c;
  logic [XW-1:0] dx, tx;

  assign accept = sites.valid && sites.ready;
  assign la = lower(sites.base_first);
  assign lb = lower(sites.base_second);
  assign a_cert = is_certain(la);
  assign b_cert = is_certain(lb);
  assign use_site = (sites.site_weight != '0) && a_cert && b_cert;
  assign differ = la != lb;
  assign tot_add = {1'b0, total_sum} + (SUM_WIDTH+1)'(sites.site_weight);
  assign dif_add = {1'b0, differ_sum} + (SUM_WIDTH+1)'(sites.site_weight);

  assign n_c  = {total_sum, 1'b0} + NW'(total_sum);
  assign d4_c = {differ_sum, 2'b00};

  assign sq = {31'b0, m} * {31'b0, m};
  assign last_step = cnt == 5'd29;
  assign ln_cur = {e, frac[28:0], sq[61]};

  assign p_lo = (LO_W+28)'(diff[LO_W-1:0]) * (LO_W+28)'(jcpd_pkg::LN2_075_Q28);
  assign p_hi = (HI_W+28)'(diff[LW-1:LO_W]) * (HI_W+28)'(jcpd_pkg::LN2_075_Q28);

  assign shv = prod >> SH;
  always_comb begin
    if (status_r == jcpd_pkg::ST_INFINITE) begin
      dist_c = jcpd_pkg::DIST_MAX;
    end else if (status_r == jcpd_pkg::ST_NO_SITES) begin
      dist_c = '0;
    end else if ((shv >> jcpd_pkg::DIST_W) != '0) begin
      dist_c = jcpd_pkg::DIST_MAX;
    end else begin
      dist_c = shv[jcpd_pkg::DIST_W-1:0];
    end
  end

  assign dx = XW'(differ_sum);
  assign tx = XW'(total_sum);

  always_comb begin
    state_next = state;
    case (state)
      jcpd_pkg::S_IDLE:   if (accept && sites.last_site) state_next = jcpd_pkg::S_CHECK;
      jcpd_pkg::S_CHECK: begin
        if (total_sum == '0 || d4_c >= n_c) state_next = jcpd_pkg::S_DONE;
        else state_next = jcpd_pkg::S_NORM;
      end
      jcpd_pkg::S_NORM:   if (x[NWX-1]) state_next = jcpd_pkg::S_LOG;
      jcpd_pkg::S_LOG: begin
        if (last_step) state_next = sel ? jcpd_pkg::S_MUL_LO : jcpd_pkg::S_NORM;
      end
      jcpd_pkg::S_MUL_LO: state_next = jcpd_pkg::S_MUL_HI;
      jcpd_pkg::S_MUL_HI: state_next = jcpd_pkg::S_DONE;
      jcpd_pkg::S_DONE:   if (load_out) state_next = jcpd_pkg::S_IDLE;
      default:            state_next = jcpd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state)
      jcpd_pkg::S_IDLE: in_ready = 1'b1;
      jcpd_pkg::S_DONE: load_out = !result.valid || result.ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  assign sites.ready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= jcpd_pkg::S_IDLE;
      differ_sum <= '0;
      total_sum  <= '0;
    end else begin
      state <= state_next;
      if (accept && use_site) begin
        total_sum <= tot_add[SUM_WIDTH] ? '1 : tot_add[SUM_WIDTH-1:0];
        if (differ) differ_sum <= dif_add[SUM_WIDTH] ? '1 : dif_add[SUM_WIDTH-1:0];
      end
      if (load_out) begin
        differ_sum <= '0;
        total_sum  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      jcpd_pkg::S_CHECK: begin
        m_val <= n_c - d4_c;
        x     <= NWX'(n_c);
        e     <= EW'(NWX - 1);
        sel   <= 1'b0;
        if (total_sum == '0) status_r <= jcpd_pkg::ST_NO_SITES;
        else if (d4_c >= n_c) status_r <= jcpd_pkg::ST_INFINITE;
        else status_r <= jcpd_pkg::ST_OK;
      end
      jcpd_pkg::S_NORM: begin
        cnt <= '0;
        if (x[NWX-1]) begin
          m <= x[NWX-1 -: 31];
        end else begin
          x <= {x[NWX-2:0], 1'b0};
          e <= e - 1'b1;
        end
      end
      jcpd_pkg::S_LOG: begin
        m    <= sq[61] ? sq[61:31] : sq[60:30];
        frac <= {frac[28:0], sq[61]};
        cnt  <= cnt + 1'b1;
        if (last_step) begin
          if (!sel) begin
            ln_n <= ln_cur;
            x    <= NWX'(m_val);
            e    <= EW'(NWX - 1);
            sel  <= 1'b1;
          end else begin
            diff <= (ln_n > ln_cur) ? ln_n - ln_cur : '0;
          end
        end
      end
      jcpd_pkg::S_MUL_LO: prod <= PW'(p_lo);
      jcpd_pkg::S_MUL_HI: prod <= prod + (PW'(p_hi) << LO_W);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (load_out) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.distance         <= dist_c;
      result.differing_weight <= dx[jcpd_pkg::OSUM_W-1:0];
      result.compared_weight  <= tx[jcpd_pkg::OSUM_W-1:0];
      result.status           <= status_r;
    end
  end

  `JCPD_ASSERT_IMPL(a_sum_order, 1'b1, differ_sum <= total_sum)
  `JCPD_ASSERT_IMPL(a_log_norm, state == jcpd_pkg::S_LOG, m[30])
  `JCPD_ASSERT_NEXT(a_last_busy, accept && sites.last_site, state == jcpd_pkg::S_CHECK)
  `JCPD_ASSERT_IMPL(a_no_sites,
    result.valid && result.status == jcpd_pkg::ST_NO_SITES,
    result.distance == '0 && result.differing_weight == '0)
endmodule

FILE: tb/jcpd_checker.sv
// Distance predictor and result scoreboard for the Jukes-Cantor pair distance core.
module jcpd_checker #(
  parameter int SUM_WIDTH = jcpd_pkg::SUM_WIDTH_DEF,
  parameter int FRAC_BITS = jcpd_pkg::FRAC_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst,
  jcpd_site_if   sites,
  jcpd_result_if result,
  output int     fails,
  output int     pending
);
  import jcpd_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0]   distance;
    logic [OSUM_W-1:0]   differing_weight;
    logic [OSUM_W-1:0]   compared_weight;
    logic [STATUS_W-1:0] status;
  } pair_result_t;

  pair_result_t expected_pairs[$];
  logic [63:0]  differ_acc;
  logic [63:0]  total_acc;

  function automatic logic [BASE_W-1:0] lower_base(logic [BASE_W-1:0] c);
    return (c >= CH_UP_A && c <= CH_UP_Z) ? c + CASE_OFS : c;
  endfunction

  function automatic bit is_acgt(logic [BASE_W-1:0] c);
    return c == CH_A || c == CH_C || c == CH_G || c == CH_T;
  endfunction

  function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b);
    logic [63:0] lim;
    logic [63:0] s;
    lim = (64'd1 << SUM_WIDTH) - 1;
    s = a + b;
    return (s > lim) ? lim : s;
  endfunction

  // log2 in Q.30, one squaring per fraction bit
  function automatic logic [63:0] log2_q30(logic [63:0] v);
    int          e;
    logic [63:0] m;
    logic [63:0] r;
    if (v == 0) return 0;
    e = 63;
    while (!v[e]) e--;
    m = (e >= 30) ? (v >> (e - 30)) : (v << (30 - e));
    r = 64'(e) << 30;
    for (int i = 29; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        r[i] = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic pair_result_t pair_distance(logic [63:0] dsum, logic [63:0] tsum);
    pair_result_t res;
    logic [63:0]  n3;
    logic [63:0]  d4;
    logic [63:0]  ln_n;
    logic [63:0]  ln_m;
    logic [63:0]  dl;
    logic [63:0]  d;
    res.differing_weight = dsum[OSUM_W-1:0];
    res.compared_weight  = tsum[OSUM_W-1:0];
    if (tsum == 0) begin
      res.status   = ST_NO_SITES;
      res.distance = '0;
    end else begin
      n3 = 3 * tsum;
      d4 = 4 * dsum;
      if (d4 >= n3) begin
        res.status   = ST_INFINITE;
        res.distance = DIST_MAX;
      end else begin
        ln_n = log2_q30(n3);
        ln_m = log2_q30(n3 - d4);
        dl = (ln_n > ln_m) ? ln_n - ln_m : 0;
        d = (dl * 64'(LN2_075_Q28)) >> (58 - FRAC_BITS);
        res.status   = ST_OK;
        res.distance = (d > 64'(DIST_MAX)) ? DIST_MAX : d[DIST_W-1:0];
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    logic [BASE_W-1:0] b1;
    logic [BASE_W-1:0] b2;
    pair_result_t      want;
    if (rst) begin
      differ_acc = 0;
      total_acc  = 0;
      expected_pairs.delete();
      fails = 0;
    end else begin
      if (sites.valid && sites.ready) begin
        b1 = lower_base(sites.base_first);
        b2 = lower_base(sites.base_second);
        if (sites.site_weight != 0 && is_acgt(b1) && is_acgt(b2)) begin
          total_acc = add_clamped(total_acc, 64'(sites.site_weight));
          if (b1 != b2) differ_acc = add_clamped(differ_acc, 64'(sites.site_weight));
        end
        if (sites.last_site) begin
          expected_pairs.insert(expected_pairs.size(), pair_distance(differ_acc, total_acc));
          differ_acc = 0;
          total_acc  = 0;
        end
      end
      if (result.valid && result.ready) begin
        if (expected_pairs.size() == 0) begin
          $error("result request with no pair pending");
          fails++;
        end else begin
          want = expected_pairs.pop_front();
          if (result.distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, result.distance);
            fails++;
          end
          if (result.differing_weight !== want.differing_weight) begin
            $error("differing_weight: expected %0d, got %0d", want.differing_weight,
                   result.differing_weight);
            fails++;
          end
          if (result.compared_weight !== want.compared_weight) begin
            $error("compared_weight: expected %0d, got %0d", want.compared_weight,
                   result.compared_weight);
            fails++;
          end
          if (result.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result.status);
            fails++;
          end
        end
      end
    end
    pending = expected_pairs.size();
  end
endmodule

FILE: tb/tb.sv
// Stimulus and verdict for the Jukes-Cantor pair distance core.
module tb;
  import jcpd_pkg::*;

  localparam int IDLE_LIMIT = 20000;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   cyc;
  int   idle_cycles;
  int   gap_left;
  int   burst_left;

  jcpd_site_if   sites_ch();
  jcpd_result_if result_ch();

  jukes_cantor_pair_distance_core i_dut (
    .clk(clk), .rst(rst), .sites(sites_ch.sink), .result(result_ch.source)
  );

  jcpd_checker i_checker (
    .clk(clk), .rst(rst), .sites(sites_ch), .result(result_ch),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // receiver: always ready, random stalls, or stall runs, by phase
  always @(negedge clk) begin
    cyc <= cyc + 1;
    case ((cyc >> 9) % 3)
      0: result_ch.ready <= 1'b1;
      1: result_ch.ready <= ($urandom_range(0, 3) != 0);
      default: result_ch.ready <= ((cyc % 16) >= $urandom_range(0, 10));
    endcase
  end

  always @(posedge clk) begin
    if (rst || (sites_ch.valid && sites_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic push_site(logic [7:0] b1, logic [7:0] b2, logic [15:0] w, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end
    if (gap_left > 0) begin
      sites_ch.valid = 1'b0;
      repeat (gap_left) @(negedge clk);
      gap_left = 0;
    end
    burst_left--;
    sites_ch.valid       = 1'b1;
    sites_ch.base_first  = b1;
    sites_ch.base_second = b2;
    sites_ch.site_weight = w;
    sites_ch.last_site   = last;
    @(posedge clk);
    while (!sites_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_base(int junk_pct);
    logic [7:0] set[8] = '{"a", "c", "g", "t", "A", "C", "G", "T"};
    if ($urandom_range(0, 99) < junk_pct) return 8'($urandom_range(0, 255));
    return set[$urandom_range(0, 7)];
  endfunction

  function automatic logic [7:0] other_base(logic [7:0] b);
    logic [7:0] b2;
    b2 = pick_base(0);
    while ((b2 | 8'h20) == (b | 8'h20)) b2 = pick_base(0);
    return b2;
  endfunction

  task automatic random_pair(int len);
    int          mut;
    int          junk;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [15:0] w;
    mut = $urandom_range(0, 100);
    junk = ($urandom_range(0, 3) == 0) ? 30 : 3;
    for (int i = 0; i < len; i++) begin
      b1 = pick_base(junk);
      b2 = ($urandom_range(0, 99) < mut) ? other_base(b1) : b1;
      if ($urandom_range(0, 1)) b2 = b2 ^ ((b2 >= "a" && b2 <= "z") ? 8'h20 : 8'h00);
      if ($urandom_range(0, 99) < junk) b2 = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
        0: w = 0;
        1: w = 16'hFFFF;
        2: w = 1;
        default: w = 16'($urandom_range(0, 65535));
      endcase
      push_site(b1, b2, w, i == len - 1);
    end
  endtask

  initial begin
    int items;
    int len;
    bit paused;
    rst = 1;
    cyc = 0;
    gap_left = 0;
    burst_left = 0;
    sites_ch.valid = 0;
    sites_ch.base_first = 0;
    sites_ch.base_second = 0;
    sites_ch.site_weight = 0;
    sites_ch.last_site = 0;
    result_ch.ready = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // no usable sites: uncertain bases, zero weight, then non-letter bytes
    push_site("n", "a", 16'd5, 1'b1);
    push_site("a", "c", 16'd0, 1'b1);
    push_site(8'hFF, 8'h00, 16'hFFFF, 1'b1);
    // identical bases, mixed case
    push_site("A", "a", 16'hFFFF, 1'b0);
    push_site("g", "G", 16'd1, 1'b1);
    // all differing: infinite
    push_site("a", "T", 16'd7, 1'b0);
    push_site("C", "g", 16'd9, 1'b1);
    // p exactly 0.75
    push_site("a", "c", 16'd1, 1'b0);
    push_site("g", "t", 16'd1, 1'b0);
    push_site("t", "a", 16'd1, 1'b0);
    push_site("c", "c", 16'd1, 1'b1);
    // p just under 0.75, large distance
    push_site("a", "c", 16'd7499, 1'b0);
    push_site("t", "t", 16'd2501, 1'b1);
    // small p
    push_site("a", "g", 16'd1, 1'b0);
    push_site("t", "t", 16'hFFFF, 1'b1);
    // long run of heavy sites
    for (int i = 0; i < 40; i++)
      push_site("a", (i % 5 == 0) ? "c" : "A", 16'hFFFF, i == 39);

    items = 0;
    paused = 0;
    while (items < 1495) begin
      if (!paused && items >= 700) begin
        sites_ch.valid = 1'b0;
        while (pending != 0) @(negedge clk);
        paused = 1;
      end
      if ($urandom_range(0, 19) == 0) len = 40;
      else if ($urandom_range(0, 4) == 0) len = 1;
      else len = $urandom_range(2, 12);
      random_pair(len);
      items += len;
    end
    sites_ch.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fails == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
